FILE: rtl/tpc_pkg.sv
`timescale 1ns / 1ps
package tpc_pkg;

  localparam int MAX_NODES     = 4096;
  localparam int ALPHABET_SIZE = 26;
  localparam int COUNT_BITS    = 16;

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int FREE_W     = $clog2(MAX_NODES + 1);
  localparam int LINK_DEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int LETTER_W   = 5;
  localparam int TOTAL_W    = 16;
  localparam int TOTAL_MAX  = 65535;

  localparam logic [1:0] STATUS_STORED   = 2'd0;
  localparam logic [1:0] STATUS_ANSWERED = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic KIND_INSERT = 1'b0;

  typedef struct packed {
    logic                kind;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] prefix_total;
    logic [1:0]         status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;     // one step of the clearing sweep
    logic accept;  // take an input transaction, issue the link read
    logic link;    // follow or allocate the child
    logic sum;     // add the child's end count
    logic cnt;     // bump the end count at the cursor
    logic emit;    // load the result register, close the string
  } tpc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_last;
    logic sum_next;
    logic cnt_next;
    logic out_free;
  } tpc_sts_t;

endpackage

FILE: rtl/trie_prefix_count_engine.sv
`timescale 1ns / 1ps
// Channel  Ports                          Payload
// input    in_valid, in_stall, in_item    kind, letter, last_letter
// result   out_valid, out_stall, out_item prefix_total, status
//
// A letter takes a link read, then a follow/allocate step, plus a sum step when a
// query adds an end count. A last letter adds a count-update step for a stored insert
// and a step to load the result register. The single-port link and count memories set this.
// After reset a clearing sweep writes all 106496 link entries, one per cycle,
// with in_stall high. A waiting result holds only the final step of a string.
module trie_prefix_count_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tpc_pkg::out_item_t  out_item
);
  import tpc_pkg::*;

  tpc_cmd_t cmd;
  tpc_sts_t sts;

  tpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/tpc_datapath.sv
`timescale 1ns / 1ps
module tpc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tpc_pkg::tpc_cmd_t   cmd,
  output tpc_pkg::tpc_sts_t   sts,
  input  tpc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tpc_pkg::out_item_t  out_item
);
  import tpc_pkg::*;

  logic [NODE_W-1:0]     child_links [LINK_DEPTH];
  logic [COUNT_BITS-1:0] end_counts  [MAX_NODES];

  logic [LINK_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [NODE_W-1:0]     cursor_r, cursor_nxt;
  logic [COUNT_BITS-1:0] sum_r, sum_nxt;
  logic                  stopped_r, stopped_nxt;
  logic                  kind_r, kind_nxt;
  logic [FREE_W-1:0]     free_r, free_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;

  logic [LINK_AW-1:0]    slot_r;
  logic                  act_r;
  logic                  last_r;
  logic [NODE_W-1:0]     lk_rdata_r;
  logic [COUNT_BITS-1:0] ec_rdata_r;

  logic                  letter_ok;
  logic [LINK_AW-1:0]    slot;
  logic                  hit, room, alloc, pool_fail, qmiss;
  logic                  lk_we;
  logic [LINK_AW-1:0]    lk_waddr;
  logic [NODE_W-1:0]     lk_wdata;
  logic                  ec_we;
  logic [NODE_W-1:0]     ec_waddr;
  logic [COUNT_BITS-1:0] ec_wdata;
  logic [COUNT_BITS:0]   sum_wide, inc_wide;
  logic                  clr_in_ec;

  assign letter_ok = 32'(in_item.letter) < ALPHABET_SIZE;
  assign slot = LINK_AW'(cursor_r) * LINK_AW'(ALPHABET_SIZE) + LINK_AW'(in_item.letter);

  assign hit       = lk_rdata_r != '0;
  assign room      = 32'(free_r) < MAX_NODES;
  assign alloc     = act_r && (kind_r == KIND_INSERT) && !hit && room;
  assign pool_fail = act_r && (kind_r == KIND_INSERT) && !hit && !room;
  assign qmiss     = act_r && (kind_r != KIND_INSERT) && !hit;

  assign sum_wide = {1'b0, sum_r} + {1'b0, ec_rdata_r};
  assign inc_wide = {1'b0, ec_rdata_r} + (COUNT_BITS+1)'(1);

  assign clr_in_ec = 32'(clr_cnt_r) < MAX_NODES;

  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = slot_r;
    lk_wdata = free_r[NODE_W-1:0];
    if (cmd.clr) begin
      lk_we    = 1'b1;
      lk_waddr = clr_cnt_r;
      lk_wdata = '0;
    end else if (cmd.link && alloc) begin
      lk_we = 1'b1;
    end
  end

  always_comb begin
    ec_we    = 1'b0;
    ec_waddr = cursor_r;
    ec_wdata = inc_wide[COUNT_BITS] ? '1 : inc_wide[COUNT_BITS-1:0];
    if (cmd.clr) begin
      ec_we    = clr_in_ec;
      ec_waddr = clr_cnt_r[NODE_W-1:0];
      ec_wdata = '0;
    end else if (cmd.cnt) begin
      ec_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      child_links[lk_waddr] <= lk_wdata;
    end
    if (cmd.accept) begin
      lk_rdata_r <= child_links[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (ec_we) begin
      end_counts[ec_waddr] <= ec_wdata;
    end
    if (cmd.link) begin
      ec_rdata_r <= end_counts[cursor_nxt];
    end
  end

  // transaction fields and per-letter walk enable
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_r <= slot;
      last_r <= in_item.last_letter;
      act_r  <= !stopped_r && letter_ok;
    end
  end

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    cursor_nxt    = cursor_r;
    sum_nxt       = sum_r;
    stopped_nxt   = stopped_r;
    kind_nxt      = kind_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.clr) begin
      clr_cnt_nxt = clr_cnt_r + LINK_AW'(1);
    end
    if (cmd.accept && cursor_r == '0 && !stopped_r) begin
      kind_nxt = in_item.kind;
    end
    if (cmd.link) begin
      if (act_r && hit) begin
        cursor_nxt = lk_rdata_r;
      end else if (alloc) begin
        cursor_nxt = free_r[NODE_W-1:0];
        free_nxt   = free_r + FREE_W'(1);
      end
      stopped_nxt = stopped_r || pool_fail || qmiss;
    end
    if (cmd.sum) begin
      sum_nxt = sum_wide[COUNT_BITS] ? '1 : sum_wide[COUNT_BITS-1:0];
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      cursor_nxt    = '0;
      sum_nxt       = '0;
      stopped_nxt   = 1'b0;
      kind_nxt      = KIND_INSERT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      cursor_r    <= '0;
      sum_r       <= '0;
      stopped_r   <= 1'b0;
      kind_r      <= KIND_INSERT;
      free_r      <= FREE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      cursor_r    <= cursor_nxt;
      sum_r       <= sum_nxt;
      stopped_r   <= stopped_nxt;
      kind_r      <= kind_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (kind_r == KIND_INSERT) begin
        out_item_r.prefix_total <= '0;
        out_item_r.status       <= stopped_r ? STATUS_FULL : STATUS_STORED;
      end else begin
        out_item_r.prefix_total <= (32'(sum_r) > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX)
                                                            : TOTAL_W'(sum_r);
        out_item_r.status       <= STATUS_ANSWERED;
      end
    end
  end

  assign sts.clr_last = 32'(clr_cnt_r) == LINK_DEPTH - 1;
  assign sts.is_last  = last_r;
  assign sts.sum_next = act_r && (kind_r != KIND_INSERT) && hit;
  assign sts.cnt_next = last_r && (kind_r == KIND_INSERT) && !stopped_nxt;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/tpc_ctrl.sv
`timescale 1ns / 1ps
module tpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tpc_pkg::tpc_sts_t  sts,
  output tpc_pkg::tpc_cmd_t  cmd
);
  import tpc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK,
    ST_SUM,
    ST_CNT,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LINK;
        end
      end
      ST_LINK: begin
        cmd.link = 1'b1;
        priority if (sts.sum_next) begin
          state_nxt = ST_SUM;
        end else if (sts.cnt_next) begin
          state_nxt = ST_CNT;
        end else if (sts.is_last) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = sts.is_last ? ST_EMIT : ST_IDLE;
      end
      ST_CNT: begin
        cmd.cnt   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold here until the result register can take the transaction
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != ST_IDLE;

endmodule

FILE: tb/sv/tb_trie_prefix_count_engine.sv
`timescale 1ns / 1ps
module tb_trie_prefix_count_engine;
  import tpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;  // covers the clearing sweep, which moves no transactions
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 1790;
  localparam int BURST_REPEATS  = 20;
  localparam int END_SETTLE     = 20;
  localparam int ITEM_W         = $bits(in_item_t);
  localparam logic KIND_QUERY   = ~KIND_INSERT;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;

  // Shadow trie: mirrors the node table and the walk of the string in progress.
  class trie_shadow;
    bit [NODE_W-1:0]     links [LINK_DEPTH];
    bit [COUNT_BITS-1:0] counts [MAX_NODES];
    int unsigned         next_free;
    bit [NODE_W-1:0]     cursor;
    bit [COUNT_BITS-1:0] sum;
    bit                  stopped;
    logic                str_kind;
    out_item_t           pending_totals[$];
    int errors, strings_done, queries_done, full_done;

    function new();
      next_free = 1;
      cursor    = '0;
      sum       = '0;
      stopped   = 1'b0;
      str_kind  = KIND_INSERT;
    endfunction

    function bit [COUNT_BITS-1:0] sat_add(bit [COUNT_BITS-1:0] a, bit [COUNT_BITS-1:0] b);
      bit [COUNT_BITS:0] s;
      s = a + b;
      return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function void take_letter(in_item_t it);
      int unsigned     slot;
      bit [NODE_W-1:0] child;
      out_item_t       res;
      // kind re-latches while the walk still sits at the root
      if (cursor == 0 && !stopped) str_kind = it.kind;
      if (!stopped && it.letter < ALPHABET_SIZE) begin
        slot  = cursor * ALPHABET_SIZE + it.letter;
        child = links[slot];
        if (str_kind == KIND_INSERT) begin
          if (child == 0 && next_free >= MAX_NODES) begin
            stopped = 1'b1;
          end else begin
            if (child == 0) begin
              child = NODE_W'(next_free);
              links[slot] = child;
              next_free++;
            end
            cursor = child;
          end
        end else if (child == 0) begin
          stopped = 1'b1;
        end else begin
          cursor = child;
          sum    = sat_add(sum, counts[child]);
        end
      end
      if (!it.last_letter) return;
      res.prefix_total = '0;
      if (str_kind == KIND_INSERT) begin
        if (stopped) begin
          res.status = STATUS_FULL;
          full_done++;
        end else begin
          counts[cursor] = sat_add(counts[cursor], COUNT_BITS'(1));
          res.status = STATUS_STORED;
        end
      end else begin
        res.prefix_total = sum;
        res.status = STATUS_ANSWERED;
        queries_done++;
      end
      strings_done++;
      pending_totals.push_back(res);
      cursor   = '0;
      sum      = '0;
      stopped  = 1'b0;
      str_kind = KIND_INSERT;
    endfunction

    task match_result(out_item_t got);
      out_item_t want;
      if (pending_totals.size() == 0) begin
        flag_mismatch($sformatf("unexpected result total=%0d status=%0d",
                                got.prefix_total, got.status));
        return;
      end
      want = pending_totals.pop_front();
      if (got.prefix_total !== want.prefix_total)
        flag_mismatch($sformatf("prefix_total got %0d want %0d",
                                got.prefix_total, want.prefix_total));
      if (got.status !== want.status)
        flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask

    task close_out();
      if (pending_totals.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", pending_totals.size()));
    endtask
  endclass

  trie_shadow shadow = new();

  trie_prefix_count_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.take_letter(it);
    items_sent++;
  endtask

  task automatic offer(input in_item_t it);
    if (!tx_quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    send_item(it);
  endtask

  // a-z letters, 0-5 out of range (26-31), uppercase flips the kind bit
  task automatic send_word(input logic k, input string w);
    in_item_t it;
    byte      c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      it.kind = k;
      if (c >= "0" && c <= "5") begin
        it.letter = LETTER_W'(26 + (c - "0"));
      end else if (c >= "A" && c <= "Z") begin
        it.letter = LETTER_W'(c - "A");
        it.kind   = ~k;
      end else begin
        it.letter = LETTER_W'(c - "a");
      end
      it.last_letter = (i == w.len() - 1);
      offer(it);
    end
  endtask

  task automatic send_random_string(input bit pool_fill);
    in_item_t it;
    int       r, len, span, n;
    logic     k;
    r = $urandom_range(0, 99);
    if (!pool_fill && r < 8) begin
      // loose transactions: may leave a string open for the next one
      n = $urandom_range(1, 4);
      repeat (n) begin
        it = ITEM_W'($urandom);
        offer(it);
      end
    end else begin
      if (pool_fill) len = $urandom_range(20, 60);
      else len = (r < 90) ? $urandom_range(1, 5) : $urandom_range(6, 14);
      span = (pool_fill || $urandom_range(0, 3) == 0) ? ALPHABET_SIZE - 1 : 3;
      k = pool_fill ? KIND_INSERT : logic'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        it.kind   = k;
        it.letter = LETTER_W'($urandom_range(0, span));
        if (!pool_fill) begin
          if ($urandom_range(0, 99) < 8) it.letter = LETTER_W'($urandom_range(26, 31));
          if ($urandom_range(0, 99) < 6) it.kind = ~k;
        end
        it.last_letter = (i == len - 1);
        offer(it);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending_totals.size() != 0);
  endtask

  initial begin : result_sink
    int stall_left, free_left, hold_left, r;
    bit stall_now;
    stall_left = 0;
    free_left  = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) shadow.match_result(out_item);
      stall_now = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        stall_now = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_now = 1'b1;
      end else if (free_left > 0) begin
        free_left--;
      end else if (!rx_quiet) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          stall_left = gap_len() - 1;
          stall_now  = 1'b1;
        end else if (r < 24) begin
          free_left = $urandom_range(20, 60);
        end
      end
      out_stall <= stall_now;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_trie_prefix_count_engine: done, errors");
    $finish;
  end

  initial begin : stimulus
    int  rand_base;
    bit  held, paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty trie, extremes, kind flips, out-of-range letters, missing children
    send_word(KIND_QUERY,  "a");
    send_word(KIND_INSERT, "a");
    send_word(KIND_INSERT, "z");
    send_word(KIND_INSERT, "ab");
    send_word(KIND_QUERY,  "abz");
    send_word(KIND_QUERY,  "aB");
    send_word(KIND_INSERT, "zZ");
    send_word(KIND_INSERT, "0a");
    send_word(KIND_INSERT, "5");
    send_word(KIND_QUERY,  "3");
    send_word(KIND_QUERY,  "1A");
    send_word(KIND_QUERY,  "ba");
    send_word(KIND_QUERY,  "a2b");
    send_word(KIND_QUERY,  "zz");

    // back-to-back burst with the receiver always ready
    drain();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (BURST_REPEATS) send_word(KIND_INSERT, "a");
    repeat (3) send_word(KIND_INSERT, "ab");
    send_word(KIND_QUERY, "ab");
    send_word(KIND_QUERY, "abc");
    send_word(KIND_QUERY, "a");
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    rand_base = items_sent;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      if (!held && items_sent - rand_base > RANDOM_ITEMS / 3) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && items_sent - rand_base > 2 * RANDOM_ITEMS / 3) begin
        drain();
        paused = 1'b1;
      end
      send_random_string(1'b0);
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    shadow.close_out();
    $display("run covered %0d letters, %0d strings (%0d queries, %0d pool-full inserts)",
             items_sent, shadow.strings_done, shadow.queries_done, shadow.full_done);
    $display("with a full-rate burst, a long receiver hold, a drain; %0d nodes in use",
             shadow.next_free);
    if (shadow.errors == 0) begin
      $display("tb_trie_prefix_count_engine: done, clean");
    end else begin
      $display("tb_trie_prefix_count_engine: done, errors");
    end
    $finish;
  end

endmodule
